@@ hw/rtl/tre_pkg.sv @@
// ----------------------------------------------------------------------------
// tre_pkg : shared types and constants of the TFTP receive engine
// Event codes, result kinds, status codes, phases and register indexes.
// ----------------------------------------------------------------------------
package tre_pkg;

	// event carried by one input transaction
	typedef enum logic [1:0] {
		ACT_START  = 2'd0,
		ACT_HEADER = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_BYTE   = 2'd3
	} action_t;

	// kind of one result transaction
	typedef enum logic [2:0] {
		KIND_SEND_RRQ = 3'd0,
		KIND_SEND_ACK = 3'd1,
		KIND_WRITE    = 3'd2,
		KIND_FINISHED = 3'd3,
		KIND_FAILED   = 3'd4
	} kind_t;

	// transfer phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_DONE = 2'd2,
		PH_FAIL = 2'd3
	} phase_t;

	// failure status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TIMEOUT  = 2'd1;
	localparam logic [1:0] ST_PEER_ERR = 2'd2;
	localparam logic [1:0] ST_PROTO    = 2'd3;

	// TFTP opcodes
	localparam logic [15:0] OP_DATA  = 16'd3;
	localparam logic [15:0] OP_ERROR = 16'd5;
	localparam logic [15:0] OP_OACK  = 16'd6;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_REQ_BLKSIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUP_ACKS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NETASCII    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OPTIONS     = 3'd4;

	// protocol constants
	localparam logic [15:0] DEFAULT_BLOCK = 16'd512;
	localparam logic [15:0] MIN_BLOCK     = 16'd8;
	localparam logic [15:0] HDR_LEN       = 16'd4;
	localparam logic [7:0]  CHAR_CR       = 8'h0D;
	localparam logic [7:0]  CHAR_NUL      = 8'h00;
	localparam logic [7:0]  RETRY_RESET   = 8'd5;

	// results caused by one event: 0..2 packet copies, then an optional tail
	typedef struct packed {
		logic [1:0]  pkt_cnt;
		logic        pkt_is_ack;
		logic [15:0] pkt_ack;
		logic        tail_vld;
		kind_t       tail_kind;
		logic [7:0]  tail_byte;
		logic [1:0]  tail_status;
		logic [15:0] bsize;
	} bundle_t;

endpackage

@@ hw/rtl/tftp_receive_engine_core.sv @@
// ----------------------------------------------------------------------------
// tftp_receive_engine_core : receive side of a TFTP read transfer
// Turns start, header, timeout and payload byte events into packet sends,
// file writes and end-of-transfer reports.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : one event per transaction (item_valid / item_stall).
//                    action selects start, received header, timeout tick or
//                    payload byte; the other fields apply to their event.
//   result channel : 0..3 result transactions per event (result_valid /
//                    result_stall); last marks the final result of an event.
//                    Events that cause nothing produce no transaction.
//   cfg channel    : register writes (cfg_valid / cfg_ready), ready is always
//                    high. Write only while the engine is quiet.
// Path: an event is registered into stage 1, decoded there, and its results
//   are registered into the stage 2 result register, which drives them out.
// Throughput: one event per cycle while each event yields at most one result
//   (payload bytes, plain ACKs) and results are not stalled. An event with
//   more than one result holds the result register until its final result
//   leaves; stage 1 keeps accepting one further event.
// Stall: a stalled result holds still; once stage 1 is also full, item_stall
//   rises in the same cycle.
// Reset: arst_n clears all control state and loads register defaults
//   (blksize 512, retry limit 5, other options off); phase is idle.
// ----------------------------------------------------------------------------
module tftp_receive_engine_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// event channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     action,
	input  logic [15:0]                    opcode,
	input  logic [15:0]                    block_number,
	input  logic [15:0]                    packet_length,
	input  logic                           has_blksize,
	input  logic [15:0]                    offered_blksize,
	input  logic [7:0]                     payload_byte,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [2:0]                     kind,
	output logic [15:0]                    ack_block,
	output logic [7:0]                     out_byte,
	output logic [1:0]                     status,
	output logic [15:0]                    block_size_in_use,
	output logic                           last,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data
);

	// ---------------- configuration registers ----------------
	logic [15:0] req_bsize_q;
	logic [7:0]  retry_limit_q;
	logic        dup_acks_q;
	logic        netascii_q;
	logic        opt_req_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bsize_q   <= tre_pkg::DEFAULT_BLOCK;
			retry_limit_q <= tre_pkg::RETRY_RESET;
			dup_acks_q    <= 1'b0;
			netascii_q    <= 1'b0;
			opt_req_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tre_pkg::REG_REQ_BLKSIZE: req_bsize_q   <= cfg_data;
				tre_pkg::REG_RETRY_LIMIT: retry_limit_q <= cfg_data[7:0];
				tre_pkg::REG_DUP_ACKS:    dup_acks_q    <= cfg_data[0];
				tre_pkg::REG_NETASCII:    netascii_q    <= cfg_data[0];
				tre_pkg::REG_OPTIONS:     opt_req_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: event register ----------------
	logic                   vld_s1;
	tre_pkg::action_t       action_s1;
	logic [15:0]            opcode_s1;
	logic [15:0]            blk_s1;
	logic [15:0]            len_s1;
	logic                   has_bs_s1;
	logic [15:0]            offer_s1;
	logic [7:0]             byte_s1;

	logic item_acc;
	logic adv_s1;     // stage 1 hands its event to the result register

	// ---------------- stage 2: result register ----------------
	tre_pkg::bundle_t bnd_s2;
	tre_pkg::bundle_t bnd_nxt;
	logic             out_acc;

	// result register frees when empty or when its final entry leaves
	assign adv_s1     = vld_s1 && (!result_valid || (out_acc && last));
	assign item_stall = vld_s1 && !adv_s1;
	assign item_acc   = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			action_s1 <= tre_pkg::action_t'(action);
			opcode_s1 <= opcode;
			blk_s1    <= block_number;
			len_s1    <= packet_length;
			has_bs_s1 <= has_blksize;
			offer_s1  <= offered_blksize;
			byte_s1   <= payload_byte;
		end
	end

	// ---------------- transfer state ----------------
	tre_pkg::phase_t phase_q,     phase_d;
	logic [15:0]     exp_blk_q,   exp_blk_d;
	logic            await_oack_q, await_oack_d;
	logic            connected_q, connected_d;
	logic [7:0]      retry_cnt_q, retry_cnt_d;
	logic [15:0]     bsize_q,     bsize_d;
	logic            prev_cr_q,   prev_cr_d;
	logic            last_ack_q,  last_ack_d;
	logic [15:0]     remain_q,    remain_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= tre_pkg::PH_IDLE;
			exp_blk_q    <= 16'd1;
			await_oack_q <= 1'b0;
			connected_q  <= 1'b0;
			retry_cnt_q  <= '0;
			bsize_q      <= tre_pkg::DEFAULT_BLOCK;
			prev_cr_q    <= 1'b0;
			last_ack_q   <= 1'b0;
			remain_q     <= '0;
		end else if (adv_s1) begin
			phase_q      <= phase_d;
			exp_blk_q    <= exp_blk_d;
			await_oack_q <= await_oack_d;
			connected_q  <= connected_d;
			retry_cnt_q  <= retry_cnt_d;
			bsize_q      <= bsize_d;
			prev_cr_q    <= prev_cr_d;
			last_ack_q   <= last_ack_d;
			remain_q     <= remain_d;
		end
	end

	// ---------------- event decode ----------------
	logic        in_wait;
	logic        hdr_err, hdr_oack, oack_bad, data_bad, blk_miss;
	logic [15:0] pay_raw, bs_eff, pay;
	logic        data_short;
	logic [7:0]  retry_inc;
	logic        tick_fail;
	logic        byte_take;
	logic        byte_hold;   // netascii CR held back, no write
	logic [7:0]  byte_val;
	logic [1:0]  copies;
	logic [15:0] prev_blk;

	always_comb begin
		in_wait    = (phase_q == tre_pkg::PH_WAIT);
		hdr_err    = (opcode_s1 == tre_pkg::OP_ERROR);
		hdr_oack   = (opcode_s1 == tre_pkg::OP_OACK);
		oack_bad   = !await_oack_q || (exp_blk_q != 16'd1) ||
		             (has_bs_s1 && ((offer_s1 < tre_pkg::MIN_BLOCK) ||
		                            (offer_s1 > req_bsize_q)));
		data_bad   = (opcode_s1 != tre_pkg::OP_DATA) || (len_s1 < tre_pkg::HDR_LEN);
		blk_miss   = (blk_s1 != exp_blk_q);
		// an awaited OACK that never came falls back to the default size
		bs_eff     = await_oack_q ? tre_pkg::DEFAULT_BLOCK : bsize_q;
		pay_raw    = len_s1 - tre_pkg::HDR_LEN;
		pay        = (pay_raw > bs_eff) ? bs_eff : pay_raw;
		data_short = (pay != bs_eff);
		retry_inc  = retry_cnt_q + 8'd1;
		tick_fail  = !((retry_inc < retry_limit_q) && (retry_inc != 8'd0));
		byte_take  = (remain_q != 16'd0);
		byte_hold  = netascii_q && !prev_cr_q && (byte_s1 == tre_pkg::CHAR_CR);
		byte_val   = (netascii_q && prev_cr_q && (byte_s1 == tre_pkg::CHAR_NUL)) ?
		             tre_pkg::CHAR_CR : byte_s1;
		// headers connect first, so they always see the connected copy count
		copies     = dup_acks_q ? 2'd2 : 2'd1;
		prev_blk   = exp_blk_q - 16'd1;
	end

	// ---------------- next state ----------------
	always_comb begin
		phase_d      = phase_q;
		exp_blk_d    = exp_blk_q;
		await_oack_d = await_oack_q;
		connected_d  = connected_q;
		retry_cnt_d  = retry_cnt_q;
		bsize_d      = bsize_q;
		prev_cr_d    = prev_cr_q;
		last_ack_d   = last_ack_q;
		remain_d     = remain_q;
		unique case (action_s1)
			tre_pkg::ACT_START: begin
				phase_d      = tre_pkg::PH_WAIT;
				exp_blk_d    = 16'd1;
				await_oack_d = opt_req_q;
				connected_d  = 1'b0;
				retry_cnt_d  = '0;
				bsize_d      = req_bsize_q;
				prev_cr_d    = 1'b0;
				last_ack_d   = 1'b0;
				remain_d     = '0;
			end
			tre_pkg::ACT_HEADER: begin
				if (in_wait) begin
					connected_d = 1'b1;
					retry_cnt_d = '0;
					remain_d    = '0;
					priority if (hdr_err) begin
						phase_d = tre_pkg::PH_FAIL;
					end else if (hdr_oack) begin
						if (oack_bad) begin
							phase_d = tre_pkg::PH_FAIL;
						end else begin
							if (has_bs_s1) begin
								bsize_d = offer_s1;
							end
							await_oack_d = 1'b0;
							last_ack_d   = 1'b1;
						end
					end else if (data_bad) begin
						phase_d = tre_pkg::PH_FAIL;
					end else if (!blk_miss) begin
						bsize_d      = bs_eff;
						await_oack_d = 1'b0;
						remain_d     = pay;
						last_ack_d   = 1'b1;
						exp_blk_d    = exp_blk_q + 16'd1;
						if (data_short) begin
							phase_d = tre_pkg::PH_DONE;
						end
					end
				end
			end
			tre_pkg::ACT_TICK: begin
				if (in_wait) begin
					retry_cnt_d = retry_inc;
					if (tick_fail) begin
						phase_d  = tre_pkg::PH_FAIL;
						remain_d = '0;
					end
				end
			end
			tre_pkg::ACT_BYTE: begin
				if (byte_take) begin
					remain_d  = remain_q - 16'd1;
					prev_cr_d = netascii_q && (prev_cr_q ? 1'b0 : byte_hold);
					if (!netascii_q) begin
						prev_cr_d = prev_cr_q;
					end
				end
			end
			default: ;
		endcase
	end

	// ---------------- results of this event ----------------
	always_comb begin
		bnd_nxt             = '0;
		bnd_nxt.tail_kind   = tre_pkg::KIND_FAILED;
		bnd_nxt.tail_status = tre_pkg::ST_OK;
		bnd_nxt.bsize       = bsize_d;
		unique case (action_s1)
			tre_pkg::ACT_START: begin
				bnd_nxt.pkt_cnt = 2'd1;   // not connected yet: one copy
			end
			tre_pkg::ACT_HEADER: begin
				if (in_wait) begin
					priority if (hdr_err) begin
						bnd_nxt.tail_vld    = 1'b1;
						bnd_nxt.tail_status = tre_pkg::ST_PEER_ERR;
					end else if (hdr_oack) begin
						if (oack_bad) begin
							bnd_nxt.tail_vld    = 1'b1;
							bnd_nxt.tail_status = tre_pkg::ST_PROTO;
						end else begin
							bnd_nxt.pkt_cnt    = copies;
							bnd_nxt.pkt_is_ack = 1'b1;
						end
					end else if (data_bad) begin
						bnd_nxt.tail_vld    = 1'b1;
						bnd_nxt.tail_status = tre_pkg::ST_PROTO;
					end else if (blk_miss) begin
						// resend the previous packet
						bnd_nxt.pkt_cnt    = copies;
						bnd_nxt.pkt_is_ack = last_ack_q;
						bnd_nxt.pkt_ack    = last_ack_q ? prev_blk : 16'd0;
					end else begin
						bnd_nxt.pkt_cnt    = copies;
						bnd_nxt.pkt_is_ack = 1'b1;
						bnd_nxt.pkt_ack    = exp_blk_q;
						if (data_short) begin
							bnd_nxt.tail_vld  = 1'b1;
							bnd_nxt.tail_kind = tre_pkg::KIND_FINISHED;
						end
					end
				end
			end
			tre_pkg::ACT_TICK: begin
				if (in_wait) begin
					if (tick_fail) begin
						bnd_nxt.tail_vld    = 1'b1;
						bnd_nxt.tail_status = tre_pkg::ST_TIMEOUT;
					end else begin
						bnd_nxt.pkt_cnt    = (connected_q && dup_acks_q) ? 2'd2 : 2'd1;
						bnd_nxt.pkt_is_ack = last_ack_q;
						bnd_nxt.pkt_ack    = last_ack_q ? prev_blk : 16'd0;
					end
				end
			end
			tre_pkg::ACT_BYTE: begin
				if (byte_take && !byte_hold) begin
					bnd_nxt.tail_vld  = 1'b1;
					bnd_nxt.tail_kind = tre_pkg::KIND_WRITE;
					bnd_nxt.tail_byte = byte_val;
				end
			end
			default: ;
		endcase
	end

	// ---------------- stage 2: result register and drain ----------------
	assign out_acc = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_s2 <= '0;
		end else if (adv_s1) begin
			bnd_s2 <= bnd_nxt;
		end else if (out_acc) begin
			// packet copies leave first, then the tail entry
			if (bnd_s2.pkt_cnt != 2'd0) begin
				bnd_s2.pkt_cnt <= bnd_s2.pkt_cnt - 2'd1;
			end else begin
				bnd_s2.tail_vld <= 1'b0;
			end
		end
	end

	always_comb begin
		result_valid      = (bnd_s2.pkt_cnt != 2'd0) || bnd_s2.tail_vld;
		block_size_in_use = bnd_s2.bsize;
		if (bnd_s2.pkt_cnt != 2'd0) begin
			kind      = bnd_s2.pkt_is_ack ? tre_pkg::KIND_SEND_ACK : tre_pkg::KIND_SEND_RRQ;
			ack_block = bnd_s2.pkt_ack;
			out_byte  = '0;
			status    = tre_pkg::ST_OK;
			last      = (bnd_s2.pkt_cnt == 2'd1) && !bnd_s2.tail_vld;
		end else begin
			kind      = bnd_s2.tail_kind;
			ack_block = '0;
			out_byte  = bnd_s2.tail_byte;
			status    = bnd_s2.tail_status;
			last      = 1'b1;
		end
	end

endmodule
